// ----- hdl/pds_pkg.sv -----
// Shared constants and types for the pixel-clock divider search.
package pds_pkg;

  // Clock chip variants
  localparam logic [1:0] CHIP_LCD   = 2'd0;
  localparam logic [1:0] CHIP_STD   = 2'd1;
  localparam logic [1:0] CHIP_CYBER = 2'd2;
  localparam logic [1:0] CHIP_RESET = CHIP_STD;

  // Divider datapath widths
  localparam int DIV_BITS = 27;                 // widest dividend, (n_lo+8)*xtal
  localparam int DEN_BITS = 14;                 // divisor up to 65*2*100
  localparam int STEP_BITS = 13;                // xtal/divisor quotient
  localparam logic [4:0] DIV_LAST = 5'(DIV_BITS - 1);

  // Reference crystal in kHz scaled by 100, and the base dividends
  localparam logic [DIV_BITS-1:0] XTAL_SCALED = 27'd1431818;
  localparam logic [DIV_BITS-1:0] BASE_CYBER  = 27'd103090896;  // (64+8)*xtal
  localparam logic [DIV_BITS-1:0] BASE_STD    = 27'd12886362;   // (1+8)*xtal
  localparam logic [DEN_BITS-1:0] DEN_SCALE   = 14'd100;

  // Search limits
  localparam logic [8:0]  MAX_DIFF = 9'd500;
  localparam logic [20:0] LOW_KHZ  = 21'd16000;
  localparam logic [20:0] HIGH_KHZ = 21'd75000;
  localparam logic [7:0]  N_LO_CYBER = 8'd64;
  localparam logic [7:0]  N_HI_CYBER = 8'd254;
  localparam logic [7:0]  N_LO_STD   = 8'd1;
  localparam logic [7:0]  N_HI_STD   = 8'd121;
  localparam logic [5:0]  M_HI_CYBER = 6'd63;
  localparam logic [5:0]  M_HI_STD   = 6'd31;

  // Misc output and register packing masks
  localparam logic [7:0] MISC_KEEP = 8'hF3;
  localparam logic [7:0] MISC_SET  = 8'h08;
  localparam logic [5:0] M_CYBER_MASK = 6'h2F;

  // Search sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV_STEP,
    ST_DIV_BASE,
    ST_SCAN,
    ST_NEXT,
    ST_FINISH
  } pds_state_t;

endpackage

// ----- hdl/pll_divider_search.sv -----
// Top level: sequential n/m/k divider search for a programmable pixel clock.
//
// Channels: an input item (target_khz, misc_current) is taken when in_valid is
// high and in_stall is low; in_stall is high while a search runs. One result
// item per input item leaves on out_valid/out_stall. A 2-bit chip_type register
// is written through cfg_valid/cfg_ready/cfg_data, only while no search runs.
// Search: for each (k, m) pair the shared restoring divider runs twice, once
// to get xtal/D and once for the base quotient at the lowest n; the same
// quotient/remainder registers then step through every n at one per cycle.
// The block works on one item at a time; in_stall stays high until the result
// is loaded into the output register.
// Reset: chip_type returns to 1, no result is pending, block is idle.
// A stalled receiver holds the result in the output register; a finished
// search waits there until the output register is free.
module pll_divider_search import pds_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [20:0] target_khz,
  input  logic [7:0]  misc_current,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        found,
  output logic [7:0]  reg_a,
  output logic [7:0]  reg_b,
  output logic        misc_write,
  output logic [7:0]  misc_value,
  output logic [20:0] achieved_khz,
  output logic [7:0]  n_value,
  output logic [5:0]  m_value,
  output logic [1:0]  k_value
);

  pds_state_t state, state_next;

  logic [1:0]  chip_type;
  logic [20:0] target;
  logic [7:0]  misc_cur;
  logic [1:0]  k;
  logic [5:0]  m;
  logic [7:0]  n;
  logic [DEN_BITS-1:0]  divisor;
  logic [DEN_BITS-1:0]  div_rem;
  logic [DIV_BITS-1:0]  div_quo;
  logic [4:0]           div_cnt;
  logic [STEP_BITS-1:0] step_q;
  logic [DEN_BITS-1:0]  step_r;
  logic [8:0]  best;
  logic        hit;
  logic [7:0]  bn;
  logic [5:0]  bm;
  logic [1:0]  bk;
  logic [20:0] bf;

  logic        take_in;
  logic        out_load;
  logic        cyber;
  logic [7:0]  n_lo, n_hi;
  logic [5:0]  m_hi;
  logic [1:0]  k_lo, k_hi;
  logic [DEN_BITS-1:0] setup_den;
  logic [DEN_BITS:0]   trial, trial_sub;
  logic                div_ge;
  logic [DEN_BITS-1:0] div_rem_it;
  logic [DIV_BITS-1:0] div_quo_it;
  logic [DEN_BITS:0]   acc_sum;
  logic                acc_c;
  logic [DEN_BITS-1:0] acc_rem;
  logic [20:0] cand_f, diff;
  logic        better;
  logic [7:0]  km1;

  // Chip-dependent ranges
  assign cyber = (chip_type == CHIP_CYBER);
  assign n_lo  = cyber ? N_LO_CYBER : N_LO_STD;
  assign n_hi  = cyber ? N_HI_CYBER : N_HI_STD;
  assign m_hi  = cyber ? M_HI_CYBER : M_HI_STD;
  assign k_lo  = (target_khz < LOW_KHZ) ? 2'd2 : 2'd1;
  assign k_hi  = (target > HIGH_KHZ) ? 2'd1 : 2'd2;

  // Divisor (m+2)*100*k for the next pair
  assign setup_den = 14'(({8'd0, m} + 14'd2) * DEN_SCALE);

  // Restoring divider iteration: one quotient bit per cycle
  assign trial      = {div_rem, div_quo[DIV_BITS-1]};
  assign div_ge     = (trial >= {1'b0, divisor});
  assign trial_sub  = trial - {1'b0, divisor};
  assign div_rem_it = div_ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
  assign div_quo_it = {div_quo[DIV_BITS-2:0], div_ge};

  // Stepping to the next n: add xtal/D as quotient and remainder
  assign acc_sum = {1'b0, div_rem} + {1'b0, step_r};
  assign acc_c   = (acc_sum >= {1'b0, divisor});
  assign acc_rem = acc_c ? DEN_BITS'(acc_sum - {1'b0, divisor}) : acc_sum[DEN_BITS-1:0];

  // Candidate distance; ties keep the lower n within the same k
  assign cand_f = div_quo[20:0];
  assign diff   = (cand_f > target) ? cand_f - target : target - cand_f;
  assign better = (diff < {12'd0, best}) ||
                  (hit && diff == {12'd0, best} && k == bk && n < bn);

  // k-1 as an 8-bit value, all ones when nothing was found
  assign km1 = {6'd0, bk} - 8'd1;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (in_valid) state_next = ST_SETUP;
      ST_SETUP:    state_next = ST_DIV_STEP;
      ST_DIV_STEP: if (div_cnt == DIV_LAST) state_next = ST_DIV_BASE;
      ST_DIV_BASE: if (div_cnt == DIV_LAST) state_next = ST_SCAN;
      ST_SCAN:     if (n == n_hi) state_next = ST_NEXT;
      ST_NEXT: begin
        if (m == m_hi && k == k_hi) state_next = ST_FINISH;
        else state_next = ST_SETUP;
      end
      ST_FINISH:   if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    cfg_ready = (state == ST_IDLE);
    in_stall  = (state != ST_IDLE);
    take_in   = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE:   take_in  = in_valid;
      ST_FINISH: out_load = !out_valid || !out_stall;
      default: begin
        take_in  = 1'b0;
        out_load = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chip_type <= CHIP_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) chip_type <= cfg_data;
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  // Search datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (take_in) begin
          target   <= target_khz;
          misc_cur <= misc_current;
          k        <= k_lo;
          m        <= 6'd1;
          best     <= MAX_DIFF;
          hit      <= 1'b0;
          bn       <= 8'd0;
          bm       <= 6'd0;
          bk       <= 2'd0;
          bf       <= 21'd0;
        end
      end
      ST_SETUP: begin
        divisor <= (k == 2'd2) ? {setup_den[DEN_BITS-2:0], 1'b0} : setup_den;
        div_quo <= XTAL_SCALED;
        div_rem <= '0;
        div_cnt <= '0;
      end
      ST_DIV_STEP: begin
        if (div_cnt == DIV_LAST) begin
          step_q  <= div_quo_it[STEP_BITS-1:0];
          step_r  <= div_rem_it;
          div_quo <= cyber ? BASE_CYBER : BASE_STD;
          div_rem <= '0;
          div_cnt <= '0;
        end else begin
          div_quo <= div_quo_it;
          div_rem <= div_rem_it;
          div_cnt <= div_cnt + 5'd1;
        end
      end
      ST_DIV_BASE: begin
        div_quo <= div_quo_it;
        div_rem <= div_rem_it;
        div_cnt <= div_cnt + 5'd1;
        n       <= n_lo;
      end
      ST_SCAN: begin
        if (better) begin
          best <= diff[8:0];
          hit  <= 1'b1;
          bn   <= n;
          bm   <= m;
          bk   <= k;
          bf   <= cand_f;
        end
        div_rem <= acc_rem;
        div_quo <= div_quo + DIV_BITS'(step_q) + DIV_BITS'(acc_c);
        n       <= n + 8'd1;
      end
      ST_NEXT: begin
        if (m == m_hi) begin
          m <= 6'd1;
          k <= k + 2'd1;
        end else begin
          m <= m + 6'd1;
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          found        <= hit;
          misc_write   <= (chip_type != CHIP_LCD);
          misc_value   <= (misc_cur & MISC_KEEP) | MISC_SET;
          achieved_khz <= bf;
          n_value      <= bn;
          m_value      <= bm;
          k_value      <= bk;
          if (cyber) begin
            reg_a <= bn;
            reg_b <= {km1[1:0], bm & M_CYBER_MASK};
          end else begin
            reg_a <= {bm[0] | bn[7], bn[6:0]};
            reg_b <= {km1[3:1], km1[0] | bm[5], bm[4:1]};
          end
        end
      end
      default: begin
        div_cnt <= '0;
      end
    endcase
  end

  // A result with nothing found carries zero dividers and frequency
  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> n_value == 8'd0 && m_value == 6'd0 &&
                            k_value == 2'd0 && achieved_khz == 21'd0)
    else $error("no-match result carries nonzero dividers");

  // Remainder stays below the divisor while stepping through n
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN |-> div_rem < divisor)
    else $error("step remainder not reduced");

  // Best distance never exceeds the acceptance window
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SCAN || state == ST_NEXT |-> best <= MAX_DIFF)
    else $error("best distance out of window");

  // A recorded hit always has a real post divider
  a_hit_k: assert property (@(posedge clk) disable iff (rst)
    state == ST_FINISH && hit |-> bk != 2'd0 && bm != 6'd0)
    else $error("hit without valid dividers");

  // An accepted item starts a search in the next cycle
  a_start: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == ST_SETUP)
    else $error("accepted item did not start search");

endmodule
